/* design/wfac_pkg.sv */
// ============================================================================
// wfac_pkg
// Shared types and constants of the worst-fit allocator with coalescing.
// ============================================================================
`default_nettype none

package wfac_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned TGT_W  = 11;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ASCAN,
        S_ADEC,
        S_MOVE,
        S_AFIN1,
        S_AFIN2,
        S_FREQ,
        S_FSCAN,
        S_FNXT,
        S_FNXD,
        S_FMRG,
        S_FFIN,
        S_REQW,
        S_OUT
    } t_state;

    // One entry of the block table, sorted by start address.
    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] len;
        logic              free;
    } t_entry;

    // One entry of the request table.
    typedef struct packed {
        logic              live;
        logic [DATA_W-1:0] start;
    } t_req;

endpackage

`default_nettype wire

/* design/worst_fit_allocator_coalescing_unit.sv */
// ============================================================================
// worst_fit_allocator_coalescing_unit
// Worst-fit cell allocator over a sorted block table, with merging on free.
// ============================================================================
// One request is handled at a time. An allocate scans the block table once,
// and a split then shifts the table entries above the chosen block up by
// one, one entry per cycle through the single table memory port, before the
// two halves of the split block are written. A free scans the table for the
// block, then shifts the entries above it down by one or two when neighbors
// merge. Both scan and shift are bound by the table memory, which gives one
// read and one write per cycle. After reset or a write of total_cells the
// block rebuilds the table as one free block in its S_INIT state.
`default_nettype none

module worst_fit_allocator_coalescing_unit #(
    parameter int unsigned MAX_REQUESTS = 1024,
    parameter int unsigned MAX_BLOCKS   = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [wfac_pkg::DATA_W-1:0]   i_cfg_total_cells,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_command,
    input  wire logic [wfac_pkg::DATA_W-1:0]   i_alloc_size,
    input  wire logic [wfac_pkg::TGT_W-1:0]    i_target_request,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_granted,
    output logic [wfac_pkg::DATA_W-1:0]        o_start_position
);

    localparam int unsigned IW  = $clog2(MAX_BLOCKS);
    localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned RW  = $clog2(MAX_REQUESTS);
    localparam int unsigned RCW = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned DW  = wfac_pkg::DATA_W;

    wfac_pkg::t_state r_state, n_state;

    logic [DW-1:0]               r_total, n_total;
    logic                        r_cmd, n_cmd;
    logic [DW-1:0]               r_size, n_size;
    logic [wfac_pkg::TGT_W-1:0]  r_tgt, n_tgt;
    logic [CW-1:0]               r_blk_cnt, n_blk_cnt;
    logic [RCW-1:0]              r_req_cnt, n_req_cnt;

    logic [CW-1:0]  r_idx, n_idx;
    logic           r_chk, n_chk;
    logic           r_found, n_found;
    logic           r_gr, n_gr;
    logic           r_split, n_split;
    logic [CW-1:0]  r_best, n_best;
    logic [DW-1:0]  r_bstart, n_bstart;
    logic [DW-1:0]  r_blen, n_blen;

    logic [DW-1:0]  r_fstart, n_fstart;
    logic [CW-1:0]  r_fidx, n_fidx;
    logic [DW-1:0]  r_prev_start, n_prev_start;
    logic [DW-1:0]  r_prev_len, n_prev_len;
    logic           r_prev_free, n_prev_free;
    logic           r_pf, n_pf;
    logic           r_nf, n_nf;
    logic [DW-1:0]  r_mlen, n_mlen;
    logic [DW-1:0]  r_mstart, n_mstart;

    logic [CW-1:0]  r_src, n_src;
    logic [CW-1:0]  r_left, n_left;
    logic           r_up, n_up;
    logic [1:0]     r_d, n_d;
    logic [CW-1:0]  r_wdst, n_wdst;

    logic           r_out_valid, n_out_valid;
    logic           r_out_granted, n_out_granted;
    logic [DW-1:0]  r_out_start, n_out_start;

    // Block table and request table memories.
    wfac_pkg::t_entry r_blk_mem [MAX_BLOCKS];
    wfac_pkg::t_entry r_blk_rd;
    logic [IW-1:0]    blk_raddr;
    logic             blk_we;
    logic [IW-1:0]    blk_waddr;
    wfac_pkg::t_entry blk_wdata;

    wfac_pkg::t_req r_req_mem [MAX_REQUESTS];
    wfac_pkg::t_req r_req_rd;
    logic [RW-1:0]  req_raddr;
    logic           req_we;
    logic [RW-1:0]  req_waddr;
    wfac_pkg::t_req req_wdata;

    logic          in_acc, cfg_acc, out_free;
    logic          issue, scan_hit, alloc_ok, tgt_ok, has_next;
    logic [CW-1:0] didx, fidx_p1, msrc, pidx;
    logic [DW-1:0] tgt_m1;

    assign o_cfg_ready      = 1'b1;
    assign cfg_acc          = i_cfg_valid;
    // A configuration write takes precedence over a new request.
    assign o_in_ready       = (r_state == wfac_pkg::S_IDLE) && !i_cfg_valid;
    assign in_acc           = i_in_valid && o_in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_out_granted;
    assign o_start_position = r_out_start;
    assign out_free         = !r_out_valid || i_out_ready;

    assign issue    = (r_idx < r_blk_cnt);
    assign didx     = r_idx - CW'(1);
    assign tgt_m1   = DW'(i_target_request) - DW'(1);
    assign fidx_p1  = r_fidx + CW'(1);
    assign has_next = (fidx_p1 < r_blk_cnt);
    assign msrc     = fidx_p1 + CW'(r_nf);
    assign pidx     = r_pf ? (r_fidx - CW'(1)) : r_fidx;

    assign scan_hit = r_chk && !r_blk_rd.free && (r_blk_rd.start == r_fstart);
    assign alloc_ok = r_found && ((r_blen == r_size) || (r_blk_cnt < CW'(MAX_BLOCKS)));
    assign tgt_ok   = (r_tgt != '0) && (DW'(r_tgt) <= DW'(r_req_cnt)) && r_req_rd.live;

    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            r_blk_mem[blk_waddr] <= blk_wdata;
        end
        r_blk_rd <= r_blk_mem[blk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (req_we) begin
            r_req_mem[req_waddr] <= req_wdata;
        end
        r_req_rd <= r_req_mem[req_raddr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wfac_pkg::S_INIT:  n_state = wfac_pkg::S_IDLE;
            wfac_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_command == wfac_pkg::CMD_ALLOC) ? wfac_pkg::S_ASCAN
                                                                 : wfac_pkg::S_FREQ;
                end
            end
            wfac_pkg::S_ASCAN: begin
                if (!issue) begin
                    n_state = wfac_pkg::S_ADEC;
                end
            end
            wfac_pkg::S_ADEC: begin
                if (!alloc_ok) begin
                    n_state = wfac_pkg::S_REQW;
                end else if (r_blen == r_size) begin
                    n_state = wfac_pkg::S_AFIN2;
                end else begin
                    n_state = wfac_pkg::S_MOVE;
                end
            end
            wfac_pkg::S_MOVE: begin
                if (r_left == '0) begin
                    n_state = (r_cmd == wfac_pkg::CMD_ALLOC) ? wfac_pkg::S_AFIN1
                                                             : wfac_pkg::S_FFIN;
                end
            end
            wfac_pkg::S_AFIN1: n_state = wfac_pkg::S_AFIN2;
            wfac_pkg::S_AFIN2: n_state = wfac_pkg::S_REQW;
            wfac_pkg::S_FREQ:  n_state = tgt_ok ? wfac_pkg::S_FSCAN : wfac_pkg::S_REQW;
            wfac_pkg::S_FSCAN: begin
                priority if (scan_hit) begin
                    n_state = wfac_pkg::S_FNXT;
                end else if (!issue) begin
                    n_state = wfac_pkg::S_REQW;
                end
            end
            wfac_pkg::S_FNXT:  n_state = wfac_pkg::S_FNXD;
            wfac_pkg::S_FNXD:  n_state = wfac_pkg::S_FMRG;
            wfac_pkg::S_FMRG:  n_state = wfac_pkg::S_MOVE;
            wfac_pkg::S_FFIN:  n_state = wfac_pkg::S_REQW;
            wfac_pkg::S_REQW: begin
                n_state = (r_cmd == wfac_pkg::CMD_ALLOC) ? wfac_pkg::S_OUT
                                                         : wfac_pkg::S_IDLE;
            end
            wfac_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = wfac_pkg::S_IDLE;
                end
            end
            default: n_state = wfac_pkg::S_INIT;
        endcase
        if (cfg_acc) begin
            n_state = wfac_pkg::S_INIT;
        end
    end

    // Datapath and memory control.
    always_comb begin
        n_total       = r_total;
        n_cmd         = r_cmd;
        n_size        = r_size;
        n_tgt         = r_tgt;
        n_blk_cnt     = r_blk_cnt;
        n_req_cnt     = r_req_cnt;
        n_idx         = r_idx;
        n_chk         = r_chk;
        n_found       = r_found;
        n_gr          = r_gr;
        n_split       = r_split;
        n_best        = r_best;
        n_bstart      = r_bstart;
        n_blen        = r_blen;
        n_fstart      = r_fstart;
        n_fidx        = r_fidx;
        n_prev_start  = r_prev_start;
        n_prev_len    = r_prev_len;
        n_prev_free   = r_prev_free;
        n_pf          = r_pf;
        n_nf          = r_nf;
        n_mlen        = r_mlen;
        n_mstart      = r_mstart;
        n_src         = r_src;
        n_left        = r_left;
        n_up          = r_up;
        n_d           = r_d;
        n_wdst        = r_wdst;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_granted = r_out_granted;
        n_out_start   = r_out_start;

        blk_raddr = r_idx[IW-1:0];
        blk_we    = 1'b0;
        blk_waddr = r_wdst[IW-1:0];
        blk_wdata = r_blk_rd;
        req_raddr = tgt_m1[RW-1:0];
        req_we    = 1'b0;
        req_waddr = r_req_cnt[RW-1:0];
        req_wdata = '{live: 1'b0, start: r_bstart};

        unique case (r_state)
            wfac_pkg::S_INIT: begin
                blk_we    = 1'b1;
                blk_waddr = '0;
                blk_wdata = '{start: '0, len: r_total, free: 1'b1};
                n_blk_cnt = CW'(1);
                n_req_cnt = '0;
            end
            wfac_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_command;
                    n_size  = i_alloc_size;
                    n_tgt   = i_target_request;
                    n_idx   = '0;
                    n_chk   = 1'b0;
                    n_found = 1'b0;
                    n_gr    = 1'b0;
                end
            end
            wfac_pkg::S_ASCAN: begin
                n_idx = issue ? (r_idx + CW'(1)) : r_idx;
                n_chk = issue;
                if (r_chk && r_blk_rd.free && (r_size != '0) && (r_blk_rd.len >= r_size)
                        && (!r_found || (r_blk_rd.len > r_blen))) begin
                    n_found  = 1'b1;
                    n_best   = didx;
                    n_bstart = r_blk_rd.start;
                    n_blen   = r_blk_rd.len;
                end
            end
            wfac_pkg::S_ADEC: begin
                n_gr    = alloc_ok;
                n_split = (r_blen != r_size);
                // Shift the entries above the chosen block up, top first.
                n_src   = r_blk_cnt - CW'(1);
                n_left  = r_blk_cnt - CW'(1) - r_best;
                n_up    = 1'b1;
                n_chk   = 1'b0;
            end
            wfac_pkg::S_MOVE: begin
                blk_raddr = r_src[IW-1:0];
                if (r_chk) begin
                    blk_we    = 1'b1;
                    blk_waddr = r_wdst[IW-1:0];
                    blk_wdata = r_blk_rd;
                end
                n_chk = (r_left != '0);
                if (r_left != '0) begin
                    n_wdst = r_up ? (r_src + CW'(1)) : (r_src - CW'(r_d));
                    n_src  = r_up ? (r_src - CW'(1)) : (r_src + CW'(1));
                    n_left = r_left - CW'(1);
                end
            end
            wfac_pkg::S_AFIN1: begin
                blk_we    = 1'b1;
                blk_waddr = IW'(r_best + CW'(1));
                blk_wdata = '{start: r_bstart + r_size, len: r_blen - r_size, free: 1'b1};
            end
            wfac_pkg::S_AFIN2: begin
                blk_we    = 1'b1;
                blk_waddr = r_best[IW-1:0];
                blk_wdata = '{start: r_bstart, len: r_size, free: 1'b0};
                if (r_split) begin
                    n_blk_cnt = r_blk_cnt + CW'(1);
                end
            end
            wfac_pkg::S_FREQ: begin
                n_fstart = r_req_rd.start;
                n_idx    = '0;
                n_chk    = 1'b0;
                if (tgt_ok) begin
                    req_we    = 1'b1;
                    req_waddr = RW'(DW'(r_tgt) - DW'(1));
                    req_wdata = '{live: 1'b0, start: r_req_rd.start};
                end
            end
            wfac_pkg::S_FSCAN: begin
                n_idx = issue ? (r_idx + CW'(1)) : r_idx;
                n_chk = issue;
                if (scan_hit) begin
                    n_fidx = didx;
                    n_mlen = r_blk_rd.len;
                    n_pf   = (didx != '0) && r_prev_free;
                end else if (r_chk) begin
                    n_prev_start = r_blk_rd.start;
                    n_prev_len   = r_blk_rd.len;
                    n_prev_free  = r_blk_rd.free;
                end
            end
            wfac_pkg::S_FNXT: begin
                blk_raddr = fidx_p1[IW-1:0];
            end
            wfac_pkg::S_FNXD: begin
                n_nf = has_next && r_blk_rd.free;
                if (has_next && r_blk_rd.free) begin
                    n_mlen = r_mlen + r_blk_rd.len;
                end
            end
            wfac_pkg::S_FMRG: begin
                n_mlen   = r_mlen + (r_pf ? r_prev_len : '0);
                n_mstart = r_pf ? r_prev_start : r_fstart;
                n_d      = {1'b0, r_pf} + {1'b0, r_nf};
                n_src    = msrc;
                n_up     = 1'b0;
                n_chk    = 1'b0;
                n_left   = ((r_pf || r_nf) && (r_blk_cnt > msrc)) ? (r_blk_cnt - msrc) : '0;
            end
            wfac_pkg::S_FFIN: begin
                blk_we    = 1'b1;
                blk_waddr = pidx[IW-1:0];
                blk_wdata = '{start: r_mstart, len: r_mlen, free: 1'b1};
                n_blk_cnt = r_blk_cnt - CW'(r_d);
            end
            wfac_pkg::S_REQW: begin
                if (r_req_cnt < RCW'(MAX_REQUESTS)) begin
                    req_we    = 1'b1;
                    req_wdata = '{live: (r_cmd == wfac_pkg::CMD_ALLOC) && r_gr,
                                  start: r_bstart};
                    n_req_cnt = r_req_cnt + RCW'(1);
                end
            end
            wfac_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_gr;
                    n_out_start   = r_gr ? (r_bstart + DW'(1)) : '0;
                end
            end
            default: begin
            end
        endcase

        if (cfg_acc) begin
            n_total = i_cfg_total_cells;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfac_pkg::S_INIT;
            r_total     <= '1;
            r_blk_cnt   <= CW'(1);
            r_req_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_blk_cnt   <= n_blk_cnt;
            r_req_cnt   <= n_req_cnt;
            r_out_valid <= n_out_valid;
            r_chk       <= n_chk;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_size        <= n_size;
        r_tgt         <= n_tgt;
        r_idx         <= n_idx;
        r_found       <= n_found;
        r_gr          <= n_gr;
        r_split       <= n_split;
        r_best        <= n_best;
        r_bstart      <= n_bstart;
        r_blen        <= n_blen;
        r_fstart      <= n_fstart;
        r_fidx        <= n_fidx;
        r_prev_start  <= n_prev_start;
        r_prev_len    <= n_prev_len;
        r_prev_free   <= n_prev_free;
        r_pf          <= n_pf;
        r_nf          <= n_nf;
        r_mlen        <= n_mlen;
        r_mstart      <= n_mstart;
        r_src         <= n_src;
        r_up          <= n_up;
        r_d           <= n_d;
        r_wdst        <= n_wdst;
        r_out_granted <= n_out_granted;
        r_out_start   <= n_out_start;
    end

    a_blk_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blk_cnt != '0) && (r_blk_cnt <= CW'(MAX_BLOCKS)))
        else $error("block count out of range");

    a_req_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_cnt <= RCW'(MAX_REQUESTS))
        else $error("request counter past its limit");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_granted) |-> (r_out_start == '0))
        else $error("failed request carries a start position");

    a_grant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_granted) |-> (r_out_start != '0))
        else $error("granted request has a zero start position");

    a_move_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wfac_pkg::S_MOVE && r_left != '0 && !cfg_acc)
            |=> (r_left == $past(r_left) - CW'(1)))
        else $error("table shift skipped an entry");

endmodule

`default_nettype wire
